// ----- design/qte_pkg.sv -----
// qte_pkg: types, constants and arctangent table for the quaternion to euler core
// no dependencies
package qte_pkg;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               pitch_clamped;
  } euler_t;

  localparam int SumW        = 34;
  localparam int ArgW        = 36;
  localparam int AngW        = 28;
  localparam int RemW        = 61;
  localparam int ResW        = 62;
  localparam int IsqrtSteps  = 31;
  localparam int AtanEntries = 24;

  localparam logic signed [AngW-1:0] HalfPi      = 28'sd26353589;
  localparam logic signed [AngW-1:0] RoundBias   = 28'sd1024;
  localparam logic signed [AngW-1:0] PitchLimit  = 28'sd12868;
  localparam logic signed [AngW-1:0] AngleLimit  = 28'sd25736;
  localparam logic signed [SumW-1:0] OneQ30      = 34'sd1073741824;

  typedef struct packed {
    logic signed [SumW-1:0] pitch_s;
    logic signed [SumW-1:0] yaw_y;
    logic signed [SumW-1:0] yaw_x;
    logic signed [SumW-1:0] roll_y;
    logic signed [SumW-1:0] roll_x;
    logic                   clamp;
  } args_t;

  typedef struct packed {
    logic signed [ArgW-1:0] x;
    logic signed [ArgW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic clamp;
    logic pos;
  } pflag_t;

  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/quaternion_to_euler_angles_core.sv -----
// quaternion_to_euler_angles_core: pipelined quaternion to pitch/yaw/roll conversion
// depends on qte_pkg; products, sums, a bit-per-stage square root, then three cordic lanes
// throughput: one transaction per cycle; the whole pipeline holds while the result stalls
// the pitch cosine comes from a 31-stage integer square root, one result bit per stage
// each angle comes from a vectoring cordic with one iteration per stage
// reset clears only the stage valid bits; payload registers are not reset
module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  qte_pkg::quat_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output qte_pkg::euler_t  out_data_o
);

  localparam int Stages = qte_pkg::IsqrtSteps + CORDIC_STEPS + 5;
  localparam logic signed [qte_pkg::AngW-1:0] NegPitchLimit = -qte_pkg::PitchLimit;

  logic              en;
  logic [Stages-1:0] vld_q;

  assign en          = !vld_q[Stages-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // products
  logic signed [31:0] wx_q, yz_q, wy_q, xz_q, wz_q, xy_q, xx_q, yy_q, zz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= in_data_i.quat_w * in_data_i.quat_x;
      yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      wy_q <= in_data_i.quat_w * in_data_i.quat_y;
      xz_q <= in_data_i.quat_x * in_data_i.quat_z;
      wz_q <= in_data_i.quat_w * in_data_i.quat_z;
      xy_q <= in_data_i.quat_x * in_data_i.quat_y;
      xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      zz_q <= in_data_i.quat_z * in_data_i.quat_z;
    end
  end

  // sums
  qte_pkg::args_t         args_d, args_q;
  logic signed [qte_pkg::SumW-1:0] mag_full;
  logic [29:0]            mag_q;
  always_comb begin
    args_d.pitch_s = (34'(wx_q) - 34'(yz_q)) <<< 1;
    args_d.yaw_y   = (34'(wy_q) + 34'(xz_q)) <<< 1;
    args_d.yaw_x   = qte_pkg::OneQ30 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    args_d.roll_y  = (34'(wz_q) + 34'(xy_q)) <<< 1;
    args_d.roll_x  = qte_pkg::OneQ30 - ((34'(xx_q) + 34'(zz_q)) <<< 1);
    args_d.clamp   = (args_d.pitch_s >= qte_pkg::OneQ30) ||
                     (args_d.pitch_s <= -qte_pkg::OneQ30);
    mag_full       = args_d.pitch_s[qte_pkg::SumW-1] ? -args_d.pitch_s : args_d.pitch_s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      args_q <= args_d;
      mag_q  <= mag_full[29:0];
    end
  end

  // remainder under the square root, then one root bit per stage
  qte_pkg::args_t                 dly_q [qte_pkg::IsqrtSteps+1];
  logic [qte_pkg::RemW-1:0]       sq_n_q [qte_pkg::IsqrtSteps+1];
  logic [qte_pkg::ResW-1:0]       sq_r_q [qte_pkg::IsqrtSteps+1];
  logic [59:0]                    mag_sq;

  assign mag_sq = mag_q * mag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0]  <= args_q;
      sq_n_q[0] <= (61'd1 << 60) - 61'(mag_sq);
      sq_r_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < qte_pkg::IsqrtSteps; k++) begin : g_isqrt
    localparam logic [qte_pkg::ResW-1:0] Bit = 62'd1 << (60 - 2 * k);
    logic [qte_pkg::ResW-1:0] trial;
    logic                     take;
    assign trial = sq_r_q[k] + Bit;
    assign take  = 62'(sq_n_q[k]) >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_q[k+1]  <= dly_q[k];
        sq_n_q[k+1] <= take ? (sq_n_q[k] - trial[qte_pkg::RemW-1:0]) : sq_n_q[k];
        sq_r_q[k+1] <= take ? ((sq_r_q[k] >> 1) + Bit) : (sq_r_q[k] >> 1);
      end
    end
  end

  // quadrant correction and cordic lanes: 0 pitch, 1 yaw, 2 roll
  qte_pkg::cordic_t lane_q [CORDIC_STEPS+1][3];
  qte_pkg::pflag_t  pf_q   [CORDIC_STEPS+1];
  qte_pkg::cordic_t pre_d  [3];
  logic signed [qte_pkg::ArgW-1:0] ax [3];
  logic signed [qte_pkg::ArgW-1:0] ay [3];

  always_comb begin
    ax[0] = 36'($signed({1'b0, sq_r_q[qte_pkg::IsqrtSteps][30:0]}));
    ay[0] = 36'(dly_q[qte_pkg::IsqrtSteps].pitch_s);
    ax[1] = 36'(dly_q[qte_pkg::IsqrtSteps].yaw_x);
    ay[1] = 36'(dly_q[qte_pkg::IsqrtSteps].yaw_y);
    ax[2] = 36'(dly_q[qte_pkg::IsqrtSteps].roll_x);
    ay[2] = 36'(dly_q[qte_pkg::IsqrtSteps].roll_y);
    for (int l = 0; l < 3; l++) begin
      pre_d[l].zero = (ax[l] == '0) && (ay[l] == '0);
      if (ax[l] < 0) begin
        if (ay[l] >= 0) begin
          pre_d[l].x   = ay[l];
          pre_d[l].y   = -ax[l];
          pre_d[l].ang = qte_pkg::HalfPi;
        end else begin
          pre_d[l].x   = -ay[l];
          pre_d[l].y   = ax[l];
          pre_d[l].ang = -qte_pkg::HalfPi;
        end
      end else begin
        pre_d[l].x   = ax[l];
        pre_d[l].y   = ay[l];
        pre_d[l].ang = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q[0]      <= pre_d;
      pf_q[0].clamp  <= dly_q[qte_pkg::IsqrtSteps].clamp;
      pf_q[0].pos    <= dly_q[qte_pkg::IsqrtSteps].pitch_s > 0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [qte_pkg::AngW-1:0] Atan = qte_pkg::atan_q24(5'(i));
    qte_pkg::cordic_t nxt [3];
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        nxt[l].zero = lane_q[i][l].zero;
        if (lane_q[i][l].y > 0) begin
          nxt[l].x   = lane_q[i][l].x + (lane_q[i][l].y >>> i);
          nxt[l].y   = lane_q[i][l].y - (lane_q[i][l].x >>> i);
          nxt[l].ang = lane_q[i][l].ang + Atan;
        end else begin
          nxt[l].x   = lane_q[i][l].x - (lane_q[i][l].y >>> i);
          nxt[l].y   = lane_q[i][l].y + (lane_q[i][l].x >>> i);
          nxt[l].ang = lane_q[i][l].ang - Atan;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        lane_q[i+1] <= nxt;
        pf_q[i+1]   <= pf_q[i];
      end
    end
  end

  // rounding to q3.13 and saturation
  logic signed [qte_pkg::AngW-1:0] rnd [3];
  logic signed [qte_pkg::AngW-1:0] sat [3];
  logic signed [qte_pkg::AngW-1:0] lim [3];
  qte_pkg::euler_t                 res_d, res_q;

  always_comb begin
    lim[0] = qte_pkg::PitchLimit;
    lim[1] = qte_pkg::AngleLimit;
    lim[2] = qte_pkg::AngleLimit;
    for (int l = 0; l < 3; l++) begin
      rnd[l] = (lane_q[CORDIC_STEPS][l].ang + qte_pkg::RoundBias) >>> 11;
      if (lane_q[CORDIC_STEPS][l].zero) begin
        sat[l] = '0;
      end else if (rnd[l] > lim[l]) begin
        sat[l] = lim[l];
      end else if (rnd[l] < -lim[l]) begin
        sat[l] = -lim[l];
      end else begin
        sat[l] = rnd[l];
      end
    end
    if (pf_q[CORDIC_STEPS].clamp) begin
      res_d.pitch_angle = pf_q[CORDIC_STEPS].pos ? qte_pkg::PitchLimit[14:0]
                                                 : NegPitchLimit[14:0];
    end else begin
      res_d.pitch_angle = sat[0][14:0];
    end
    res_d.yaw_angle     = sat[1][15:0];
    res_d.roll_angle    = sat[2][15:0];
    res_d.pitch_clamped = pf_q[CORDIC_STEPS].clamp;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

  a_clamp_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pitch_clamped |->
      (out_data_o.pitch_angle == 15'sd12868) || (out_data_o.pitch_angle == -15'sd12868))
    else $error("clamped pitch not at limit");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.pitch_angle <= 15'sd12868) && (out_data_o.pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.yaw_angle <= 16'sd25736) && (out_data_o.yaw_angle >= -16'sd25736) &&
      (out_data_o.roll_angle <= 16'sd25736) && (out_data_o.roll_angle >= -16'sd25736))
    else $error("yaw or roll out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && $stable(res_q))
    else $error("pipeline moved while stalled");

endmodule
